### rtl/rar_pkg.sv
// Shared constants, codes and types for the rectangle aspect ratio block.
// Used by rar_mul, rar_root and rectangle_aspect_ratio_top; no dependencies.
`default_nettype none

package rar_pkg;

  localparam int NUM_CORNERS = 4;
  localparam int HDIM        = 3;
  localparam int OMEGA_W     = 48;
  localparam int NUM_OMEGA   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int RATIO_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int QUOT_W      = 64;
  localparam int MUL_DIG     = 16;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONPOS   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_00 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_02 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_11 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_12 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OMEGA_22 = 3'd5;

  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctl_t;

  // row and column of each symmetric conic entry, in register order
  function automatic int pair_row(input int k);
    case (k)
      0, 1, 2: pair_row = 0;
      3, 4:    pair_row = 1;
      default: pair_row = 2;
    endcase
  endfunction

  function automatic int pair_col(input int k);
    case (k)
      0:       pair_col = 0;
      1, 3:    pair_col = 1;
      default: pair_col = 2;
    endcase
  endfunction

endpackage

`default_nettype wire

### rtl/rar_mul.sv
// Pipelined unsigned multiplier lanes, one 16-bit digit of b per stage.
// Carries a side bus alongside the products; uses rar_pkg.
`default_nettype none

module rar_mul #(
  parameter int LANES = 1,
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int SW    = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rar_pkg::stage_ctl_t             ctl,
  input  wire logic [LANES-1:0][WA-1:0]        a,
  input  wire logic [LANES-1:0][WB-1:0]        b,
  input  wire logic [SW-1:0]                   side,
  output logic                                 vld_out,
  output logic [LANES-1:0][WA+WB-1:0]          p,
  output logic [SW-1:0]                        side_out
);

  localparam int DIG  = rar_pkg::MUL_DIG;
  localparam int ND   = (WB + DIG - 1) / DIG;
  localparam int BP   = ND * DIG;
  localparam int PWID = WA + WB;

  logic [LANES-1:0][WA-1:0]   ar      [ND];
  logic [LANES-1:0][BP-1:0]   br      [ND];
  logic [LANES-1:0][PWID-1:0] acc     [ND];
  logic [SW-1:0]              sd      [ND];
  logic [ND-1:0]              v;

  logic [LANES-1:0][WA-1:0]   a_src   [ND];
  logic [LANES-1:0][BP-1:0]   b_src   [ND];
  logic [LANES-1:0][PWID-1:0] acc_src [ND];
  logic [LANES-1:0][PWID-1:0] acc_next[ND];
  logic [SW-1:0]              sd_src  [ND];
  logic [ND-1:0]              v_src;

  always_comb begin
    logic [DIG-1:0]    dig;
    logic [WA+DIG-1:0] pp;
    for (int l = 0; l < LANES; l++) begin
      a_src[0][l]   = a[l];
      b_src[0][l]   = BP'(b[l]);
      acc_src[0][l] = '0;
    end
    sd_src[0] = side;
    v_src[0]  = ctl.vld;
    for (int k = 1; k < ND; k++) begin
      a_src[k]   = ar[k-1];
      b_src[k]   = br[k-1];
      acc_src[k] = acc[k-1];
      sd_src[k]  = sd[k-1];
      v_src[k]   = v[k-1];
    end
    for (int k = 0; k < ND; k++) begin
      for (int l = 0; l < LANES; l++) begin
        dig = b_src[k][l][k*DIG +: DIG];
        pp  = (WA+DIG)'(a_src[k][l]) * (WA+DIG)'(dig);
        acc_next[k][l] = acc_src[k][l] + (PWID'(pp) << (k*DIG));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ctl.en) begin
      v <= v_src;
    end
    if (ctl.en) begin
      ar  <= a_src;
      br  <= b_src;
      acc <= acc_next;
      sd  <= sd_src;
    end
  end

  assign vld_out  = v[ND-1];
  assign p        = acc[ND-1];
  assign side_out = sd[ND-1];

endmodule

`default_nettype wire

### rtl/rar_root.sv
// Pipelined restoring divider (64 quotient bits) and integer square root.
// Forms floor(sqrt(num * 2^32 / den)) with saturation; uses rar_pkg.
`default_nettype none

module rar_root #(
  parameter int NUMW = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rar_pkg::stage_ctl_t              ctl,
  input  wire logic [NUMW-1:0]                  num,
  input  wire logic [NUMW-1:0]                  den,
  input  wire logic [rar_pkg::STATUS_W-1:0]     st_in,
  output logic                                  vld_out,
  output logic [rar_pkg::RATIO_W-1:0]           ratio,
  output logic [rar_pkg::STATUS_W-1:0]          st_out
);

  localparam int QB   = rar_pkg::QUOT_W;
  localparam int HALF = QB / 2;
  localparam int RB   = rar_pkg::RATIO_W;
  localparam int SB   = rar_pkg::STATUS_W;

  // entry stage
  logic [NUMW-1:0] e_r, e_den;
  logic [HALF-1:0] e_xl;
  logic            e_sat, e_v;
  logic [SB-1:0]   e_st;

  // divider stages
  logic [NUMW-1:0] dr [QB], dd [QB];
  logic [HALF-1:0] dxl [QB];
  logic [QB-1:0]   dq [QB];
  logic [QB-1:0]   dsat, dv;
  logic [SB-1:0]   dst [QB];

  logic [NUMW-1:0] r_s [QB], den_s [QB], r_n [QB];
  logic [HALF-1:0] xl_s [QB], xl_n [QB];
  logic [QB-1:0]   q_s [QB], q_n [QB];
  logic [QB-1:0]   sat_s, v_s;
  logic [SB-1:0]   st_s [QB];

  // root stages
  logic [QB-1:0]   sv [RB], sres [RB];
  logic [RB-1:0]   ssat, svld;
  logic [SB-1:0]   sst [RB];

  logic [QB-1:0]   sv_s [RB], sres_s [RB], sv_n [RB], sres_n [RB];
  logic [RB-1:0]   ssat_s, svld_s;
  logic [SB-1:0]   sst_s [RB];

  logic [NUMW+HALF-1:0] numx, denx;

  always_comb begin
    numx = (NUMW+HALF)'(num);
    denx = {den, {HALF{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (ctl.en) begin
      e_v <= ctl.vld;
    end
    if (ctl.en) begin
      e_r   <= NUMW'(num >> HALF);
      e_den <= den;
      e_xl  <= num[HALF-1:0];
      e_sat <= (numx >= denx);
      e_st  <= st_in;
    end
  end

  always_comb begin
    logic [NUMW:0] r2;
    logic          ge;
    r_s[0]   = e_r;
    den_s[0] = e_den;
    xl_s[0]  = e_xl;
    q_s[0]   = '0;
    sat_s[0] = e_sat;
    st_s[0]  = e_st;
    v_s[0]   = e_v;
    for (int k = 1; k < QB; k++) begin
      r_s[k]   = dr[k-1];
      den_s[k] = dd[k-1];
      xl_s[k]  = dxl[k-1];
      q_s[k]   = dq[k-1];
      sat_s[k] = dsat[k-1];
      st_s[k]  = dst[k-1];
      v_s[k]   = dv[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      r2      = {r_s[k], xl_s[k][HALF-1]};
      ge      = (r2 >= {1'b0, den_s[k]});
      r_n[k]  = ge ? NUMW'(r2 - {1'b0, den_s[k]}) : NUMW'(r2);
      xl_n[k] = xl_s[k] << 1;
      q_n[k]  = {q_s[k][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (ctl.en) begin
      dv <= v_s;
    end
    if (ctl.en) begin
      dr   <= r_n;
      dd   <= den_s;
      dxl  <= xl_n;
      dq   <= q_n;
      dsat <= sat_s;
      dst  <= st_s;
    end
  end

  always_comb begin
    logic [QB:0]   s;
    logic [QB-1:0] bt;
    sv_s[0]   = dq[QB-1];
    sres_s[0] = '0;
    ssat_s[0] = dsat[QB-1];
    sst_s[0]  = dst[QB-1];
    svld_s[0] = dv[QB-1];
    for (int j = 1; j < RB; j++) begin
      sv_s[j]   = sv[j-1];
      sres_s[j] = sres[j-1];
      ssat_s[j] = ssat[j-1];
      sst_s[j]  = sst[j-1];
      svld_s[j] = svld[j-1];
    end
    for (int j = 0; j < RB; j++) begin
      bt = QB'(1) << (QB - 2 - 2*j);
      s  = {1'b0, sres_s[j]} + {1'b0, bt};
      if ({1'b0, sv_s[j]} >= s) begin
        sv_n[j]   = sv_s[j] - s[QB-1:0];
        sres_n[j] = (sres_s[j] >> 1) + bt;
      end else begin
        sv_n[j]   = sv_s[j];
        sres_n[j] = sres_s[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      svld    <= '0;
      vld_out <= 1'b0;
    end else if (ctl.en) begin
      svld    <= svld_s;
      vld_out <= svld[RB-1];
    end
    if (ctl.en) begin
      sv     <= sv_n;
      sres   <= sres_n;
      ssat   <= ssat_s;
      sst    <= sst_s;
      st_out <= sst[RB-1];
      if (sst[RB-1] != rar_pkg::ST_OK) begin
        ratio <= '0;
      end else if (ssat[RB-1]) begin
        ratio <= '1;
      end else begin
        ratio <= sres[RB-1][RB-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rectangle_aspect_ratio_top.sv
// Top level: true aspect ratio of a rectangle from its four image corners.
// Depends on rar_pkg, rar_mul and rar_root.
//
//  channel  | dir | fields (low bit first)
//  s_axis   | in  | tdata: corner1_x, corner1_y, ... corner4_x, corner4_y
//  m_axis   | out | tdata: aspect_ratio; tuser: status
//  cfg      | in  | cfg_addr selects omega_00..omega_22, cfg_wdata 48 bits
//
// Accepts one transaction per cycle while m_axis is not stalled; rar_root holds
// the 64-step divider and the 32-step square root.
// rst is synchronous and clears valid bits and omega registers.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
`default_nettype none

module rectangle_aspect_ratio_top #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y, corner4_x, corner4_y
  input  wire logic [2*rar_pkg::NUM_CORNERS*COORD_BITS-1:0] s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // aspect_ratio
  output logic [rar_pkg::RATIO_W-1:0]                    m_axis_tdata,
  // status
  output logic [rar_pkg::STATUS_W-1:0]                   m_axis_tuser,
  input  wire logic                                      cfg_we,
  input  wire logic [rar_pkg::CFG_IDX_W-1:0]             cfg_addr,
  input  wire logic [rar_pkg::OMEGA_W-1:0]               cfg_wdata
);

  localparam int C    = COORD_BITS;
  localparam int NC   = rar_pkg::NUM_CORNERS;
  localparam int HD   = rar_pkg::HDIM;
  localparam int NN   = 2 * HD;
  localparam int DW   = 2*C + 3;
  localparam int NW   = 3*C + 5;
  localparam int NM   = NW - 1;
  localparam int PW   = 2 * NM;
  localparam int OW   = rar_pkg::OMEGA_W;
  localparam int TW   = OW + PW;
  localparam int QW   = TW + 5;
  localparam int QM   = QW - 1;
  localparam int SQW  = 2 * DW;
  localparam int NUMW = QM + SQW;
  localparam int NO   = rar_pkg::NUM_OMEGA;
  localparam int NL   = 2 * NO;
  localparam int SW   = NL + 1 + 2*SQW;
  localparam int STW  = rar_pkg::STATUS_W;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // configuration
  logic [OW-1:0]          omega [NO];
  logic [NO-1:0]          wneg;
  logic [NO-1:0][OW-1:0]  wmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NO; k++) omega[k] <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        rar_pkg::REG_OMEGA_00: omega[0] <= cfg_wdata;
        rar_pkg::REG_OMEGA_01: omega[1] <= cfg_wdata;
        rar_pkg::REG_OMEGA_02: omega[2] <= cfg_wdata;
        rar_pkg::REG_OMEGA_11: omega[3] <= cfg_wdata;
        rar_pkg::REG_OMEGA_12: omega[4] <= cfg_wdata;
        rar_pkg::REG_OMEGA_22: omega[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < NO; k++) begin
      wneg[k] = omega[k][OW-1];
      wmag[k] = wneg[k] ? OW'(~omega[k] + 1'b1) : omega[k];
    end
  end

  function automatic logic signed [DW-1:0] det3(
    input logic [C-1:0] ax, input logic [C-1:0] ay,
    input logic [C-1:0] bx, input logic [C-1:0] by,
    input logic [C-1:0] qx, input logic [C-1:0] qy
  );
    logic signed [DW-1:0] axs, ays, bxs, bys, qxs, qys;
    axs = DW'(ax);
    ays = DW'(ay);
    bxs = DW'(bx);
    bys = DW'(by);
    qxs = DW'(qx);
    qys = DW'(qy);
    det3 = axs*(bys - qys) - ays*(bxs - qxs) + bxs*qys - bys*qxs;
  endfunction

  // stage 0: input register
  logic [C-1:0] cx [NC], cy [NC];
  logic         v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
    end
    if (adv) begin
      for (int i = 0; i < NC; i++) begin
        cx[i] <= s_axis_tdata[2*i*C +: C];
        cy[i] <= s_axis_tdata[(2*i+1)*C +: C];
      end
    end
  end

  // stage 1: determinants
  logic signed [DW-1:0] d1, d2, e1, e2;
  logic [C-1:0]         mx0, my0, mx1, my1, mx3, my3;
  logic                 v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
    if (adv) begin
      d1  <= det3(cx[0], cy[0], cx[2], cy[2], cx[3], cy[3]);
      d2  <= det3(cx[1], cy[1], cx[2], cy[2], cx[3], cy[3]);
      e1  <= det3(cx[0], cy[0], cx[2], cy[2], cx[1], cy[1]);
      e2  <= det3(cx[3], cy[3], cx[2], cy[2], cx[1], cy[1]);
      mx0 <= cx[0];
      my0 <= cy[0];
      mx1 <= cx[1];
      my1 <= cy[1];
      mx3 <= cx[3];
      my3 <= cy[3];
    end
  end

  // stage 2: scaled normals and squared denominators
  logic signed [NW-1:0] nr [NN], n_next [NN];
  logic [SQW-1:0]       d2sq, e2sq, d2sq_next, e2sq_next;
  logic                 zf2, v2;

  always_comb begin
    logic signed [NW-1:0] d1w, d2w, e1w, e2w, x0, y0, x1, y1, x3, y3;
    logic [DW-1:0]        d2m, e2m;
    d1w = NW'(d1);
    d2w = NW'(d2);
    e1w = NW'(e1);
    e2w = NW'(e2);
    x0  = NW'(mx0);
    y0  = NW'(my0);
    x1  = NW'(mx1);
    y1  = NW'(my1);
    x3  = NW'(mx3);
    y3  = NW'(my3);
    n_next[0] = d1w*x1 - d2w*x0;
    n_next[1] = d1w*y1 - d2w*y0;
    n_next[2] = d1w - d2w;
    n_next[3] = e1w*x3 - e2w*x0;
    n_next[4] = e1w*y3 - e2w*y0;
    n_next[5] = e1w - e2w;
    d2m = d2[DW-1] ? DW'(-d2) : DW'(d2);
    e2m = e2[DW-1] ? DW'(-e2) : DW'(e2);
    d2sq_next = SQW'(d2m) * SQW'(d2m);
    e2sq_next = SQW'(e2m) * SQW'(e2m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      nr   <= n_next;
      d2sq <= d2sq_next;
      e2sq <= e2sq_next;
      zf2  <= (d2 == '0) || (e2 == '0);
    end
  end

  // normal component products
  logic [NL-1:0][NM-1:0]  m1a, m1b;
  logic [NL-1:0]          psgn;
  logic [SW-1:0]          s1_in, s1_out;
  logic [NL-1:0][PW-1:0]  m1p;
  logic                   v_m1;
  rar_pkg::stage_ctl_t    ctl1, ctl2, ctl3, ctlr;

  always_comb begin
    logic signed [NW-1:0] x, y;
    for (int l = 0; l < NL; l++) begin
      x = nr[(l / NO)*HD + rar_pkg::pair_row(l % NO)];
      y = nr[(l / NO)*HD + rar_pkg::pair_col(l % NO)];
      m1a[l]  = x[NW-1] ? NM'(-x) : NM'(x);
      m1b[l]  = y[NW-1] ? NM'(-y) : NM'(y);
      psgn[l] = x[NW-1] ^ y[NW-1];
    end
  end

  assign s1_in = {psgn, zf2, d2sq, e2sq};
  assign ctl1  = '{en: adv, vld: v2};

  rar_mul #(.LANES(NL), .WA(NM), .WB(NM), .SW(SW)) u_mul_n (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl1),
    .a        (m1a),
    .b        (m1b),
    .side     (s1_in),
    .vld_out  (v_m1),
    .p        (m1p),
    .side_out (s1_out)
  );

  // weight by omega magnitudes
  logic [NL-1:0][OW-1:0]  m2b;
  logic [NL-1:0]          wrep;
  logic [SW-1:0]          s2_in, s2_out;
  logic [NL-1:0][TW-1:0]  m2p;
  logic                   v_m2;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      m2b[l]  = wmag[l % NO];
      wrep[l] = wneg[l % NO];
    end
  end

  assign s2_in = {s1_out[SW-1 -: NL] ^ wrep, s1_out[SW-NL-1:0]};
  assign ctl2  = '{en: adv, vld: v_m1};

  rar_mul #(.LANES(NL), .WA(PW), .WB(OW), .SW(SW)) u_mul_w (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl2),
    .a        (m1p),
    .b        (m2b),
    .side     (s2_in),
    .vld_out  (v_m2),
    .p        (m2p),
    .side_out (s2_out)
  );

  // stage A: partial sums of signed terms
  logic [NL-1:0]        sg2;
  logic signed [QW-1:0] psa [4], psa_next [4];
  logic [SQW-1:0]       d2sq_a, e2sq_a, d2sq_b, e2sq_b;
  logic                 zf_a, zf_b, va, vb;

  assign sg2 = s2_out[SW-1 -: NL];

  always_comb begin
    logic signed [QW-1:0] x, acc;
    int                   l;
    for (int g = 0; g < 4; g++) begin
      acc = '0;
      for (int j = 0; j < NO/2; j++) begin
        l = g*(NO/2) + j;
        x = QW'(m2p[l]);
        if (rar_pkg::pair_row(l % NO) != rar_pkg::pair_col(l % NO)) x = x <<< 1;
        if (sg2[l]) x = -x;
        acc = acc + x;
      end
      psa_next[g] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= v_m2;
      vb <= va;
    end
    if (adv) begin
      psa    <= psa_next;
      zf_a   <= s2_out[2*SQW];
      d2sq_a <= s2_out[2*SQW-1:SQW];
      e2sq_a <= s2_out[SQW-1:0];
      zf_b   <= zf_a;
      d2sq_b <= d2sq_a;
      e2sq_b <= e2sq_a;
    end
  end

  // stage B: full quadratic forms
  logic signed [QW-1:0] qb [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      qb[0] <= psa[0] + psa[1];
      qb[1] <= psa[2] + psa[3];
    end
  end

  // stage C: classify and take magnitudes
  logic [STW-1:0]  st_c, st_c_next;
  logic [QM-1:0]   qm [2];
  logic [SQW-1:0]  d2sq_c, e2sq_c;
  logic            vc;

  always_comb begin
    if (zf_b) begin
      st_c_next = rar_pkg::ST_ZERO_DEN;
    end else if (qb[0] == '0 || qb[1] == '0 || qb[0][QW-1] != qb[1][QW-1]) begin
      st_c_next = rar_pkg::ST_NONPOS;
    end else begin
      st_c_next = rar_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (adv) begin
      vc <= vb;
    end
    if (adv) begin
      st_c   <= st_c_next;
      qm[0]  <= qb[0][QW-1] ? QM'(-qb[0]) : QM'(qb[0]);
      qm[1]  <= qb[1][QW-1] ? QM'(-qb[1]) : QM'(qb[1]);
      d2sq_c <= d2sq_b;
      e2sq_c <= e2sq_b;
    end
  end

  // cross-multiply by squared denominators
  logic [1:0][QM-1:0]    m3a;
  logic [1:0][SQW-1:0]   m3b;
  logic [1:0][NUMW-1:0]  m3p;
  logic [STW-1:0]        st_m3;
  logic                  v_m3;

  assign m3a  = {qm[1], qm[0]};
  assign m3b  = {d2sq_c, e2sq_c};
  assign ctl3 = '{en: adv, vld: vc};

  rar_mul #(.LANES(2), .WA(QM), .WB(SQW), .SW(STW)) u_mul_x (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl3),
    .a        (m3a),
    .b        (m3b),
    .side     (st_c),
    .vld_out  (v_m3),
    .p        (m3p),
    .side_out (st_m3)
  );

  assign ctlr = '{en: adv, vld: v_m3};

  rar_root #(.NUMW(NUMW)) u_root (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctlr),
    .num     (m3p[0]),
    .den     (m3p[1]),
    .st_in   (st_m3),
    .vld_out (m_axis_tvalid),
    .ratio   (m_axis_tdata),
    .st_out  (m_axis_tuser)
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == rar_pkg::ST_OK || m_axis_tuser == rar_pkg::ST_ZERO_DEN ||
                       m_axis_tuser == rar_pkg::ST_NONPOS))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != rar_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("error result carries a nonzero ratio");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_zero_den_class: assert property (@(posedge clk) disable iff (rst)
    (adv && zf_b) |=> (st_c == rar_pkg::ST_ZERO_DEN))
    else $error("zero denominator flag lost");

endmodule

`default_nettype wire
